@@ src/gs_pkg.sv @@
// Shared types and constants for the Gauss-Seidel solver core.
package gs_pkg;

	localparam int MAX_N = 16;
	localparam int IN_ROW_W = 4;
	localparam int OUT_IDX_W = 4;

	typedef enum logic [1:0] {
		MODE_MATRIX = 2'd0,
		MODE_RHS    = 2'd1,
		MODE_SOLVE  = 2'd2,
		MODE_NONE   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_CONVERGED = 2'd0,
		ST_LIMIT     = 2'd1,
		ST_ZERO_DIAG = 2'd2
	} status_t;

	localparam logic [1:0] CFG_SIZE = 2'd0;
	localparam logic [1:0] CFG_TOL  = 2'd1;
	localparam logic [1:0] CFG_MAXS = 2'd2;

	typedef struct packed {
		logic [1:0]         mode;
		logic [3:0]         row;
		logic [3:0]         column;
		logic signed [31:0] value;
	} in_item_t;

	typedef struct packed {
		logic [3:0]         index;
		logic signed [31:0] solution;
		logic               last;
		logic [1:0]         status;
		logic [15:0]        sweeps_done;
		logic [30:0]        final_change;
	} out_item_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CLEAR,
		S_DIAG,
		S_DIAG_CHK,
		S_MAC,
		S_MAC_WAIT,
		S_DIV,
		S_DIV_WAIT,
		S_UPDATE,
		S_SWEEP_END,
		S_EMIT_RD,
		S_EMIT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clear_x;
		logic rd_diag;
		logic chk_diag;
		logic mac_start;
		logic mac_step;
		logic div_start;
		logic update;
		logic sweep_end;
		logic rd_emit;
	} gs_cmd_t;

	// Status returned by the datapath.
	typedef struct packed {
		logic diag_zero;
		logic div_done;
		logic converged;
	} gs_sts_t;

endpackage

@@ src/gauss_seidel_linear_solver_core.sv @@
// Top level of the Gauss-Seidel linear solver core.
//
//  channel  direction  handshake          payload
//  in       input      in_valid/in_stall   gs_pkg::in_item_t
//  out      output     out_valid/out_stall gs_pkg::out_item_t
//  cfg      input      cfg_valid/cfg_ready index, data
//
// Load items are accepted while the core is idle; in_stall is high during a solve. A solve first
// clears the unknowns and checks each diagonal entry, then runs sweeps: for each unknown,
// n reads through the multiply-accumulate stages, a drain of those stages, the start and
// wait of the 80-step bit-serial divider, and one update.
// Results leave one item at a time, read from the unknown store into the output
// register. Reset clears control state and restores the configuration defaults.
// A stalled output holds its item in the output register and the controller waits.
module gauss_seidel_linear_solver_core #(
	parameter int FRAC_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  gs_pkg::in_item_t  in_item,
	output logic              out_valid,
	input  logic              out_stall,
	output gs_pkg::out_item_t out_item,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [31:0]       cfg_data
);
	import gs_pkg::*;

	localparam int IW = 4;

	logic [4:0]         size_q;
	logic [30:0]        tol_q;
	logic [15:0]        maxs_q;
	gs_cmd_t            cmd;
	gs_sts_t            sts;
	logic               wr_a, wr_b;
	logic [IW-1:0]      row_i, col_j;
	logic signed [31:0] x_out;
	logic [30:0]        change;
	logic               out_load, out_last;
	logic [1:0]         out_status;
	logic [15:0]        out_sweeps;
	logic               out_free;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= 5'd4;
			tol_q <= 31'd66;
			maxs_q <= 16'd100;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_SIZE: size_q <= cfg_data[4:0];
				CFG_TOL:  tol_q <= cfg_data[30:0];
				CFG_MAXS: maxs_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	gs_ctrl #(.IW(IW)) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_item     (in_item),
		.system_size (size_q),
		.max_sweeps  (maxs_q),
		.cmd         (cmd),
		.sts         (sts),
		.wr_a        (wr_a),
		.wr_b        (wr_b),
		.row_i       (row_i),
		.col_j       (col_j),
		.out_load    (out_load),
		.out_free    (out_free),
		.out_last    (out_last),
		.out_status  (out_status),
		.out_sweeps  (out_sweeps)
	);

	gs_datapath #(.FRAC_BITS(FRAC_BITS), .IW(IW)) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.wr_a       (wr_a),
		.wr_b       (wr_b),
		.wr_row     (in_item.row),
		.wr_col     (in_item.column),
		.wr_val     (in_item.value),
		.row_i      (row_i),
		.col_j      (col_j),
		.tolerance  (tol_q),
		.x_out      (x_out),
		.change_out (change)
	);

	assign out_free = !out_valid || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (out_load)
			out_valid <= 1'b1;
		else if (!out_stall)
			out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_item.index <= row_i;
			out_item.solution <= (out_status == ST_ZERO_DIAG) ? 32'sd0 : x_out;
			out_item.last <= out_last;
			out_item.status <= out_status;
			out_item.sweeps_done <= out_sweeps;
			out_item.final_change <= (out_status == ST_ZERO_DIAG) ? 31'd0 : change;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out_item)))
		else $error("stalled output item changed");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> out_free)
		else $error("output register overwritten");
	a_no_out_when_loading: assert property (@(posedge clk) disable iff (!arst_n)
		(!in_stall && in_valid) |-> !out_load)
		else $error("result produced while accepting");

endmodule

@@ src/gs_divider.sv @@
// Restoring divider for signed fixed-point quotients with saturation.
module gs_divider #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [63:0] num,
	input  logic signed [31:0] den,
	output logic               done,
	output logic signed [31:0] quot
);
	import gs_pkg::*;

	// Dividend magnitude shifted left by FRAC_BITS; quotient bits above bit 31 saturate.
	localparam int DW = 64 + FRAC_BITS;
	localparam int CW = $clog2(DW + 1);

	logic [DW-1:0] dvd_q;
	logic [32:0]   rem_q;
	logic [31:0]   dsr_q;
	logic [DW-1:0] q_q;
	logic          neg_q;
	logic          busy_q;
	logic [CW-1:0] cnt_q;
	logic [63:0]   num_mag;
	logic [32:0]   rem_sh;
	logic [33:0]   diff;
	logic [31:0]   limit;
	logic          over;

	always_comb begin
		num_mag = num[63] ? (64'd0 - num) : num;
		rem_sh = {rem_q[31:0], dvd_q[DW-1]};
		diff = {1'b0, rem_sh} - {2'b00, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= {num_mag, {FRAC_BITS{1'b0}}};
			dsr_q <= den[31] ? (32'd0 - den) : den;
			rem_q <= '0;
			q_q <= '0;
			neg_q <= num[63] ^ den[31];
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DW-2:0], 1'b0};
			if (!diff[33]) begin
				rem_q <= diff[32:0];
				q_q <= {q_q[DW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				q_q <= {q_q[DW-2:0], 1'b0};
			end
		end
	end

	always_comb begin
		limit = neg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
		over = (|q_q[DW-1:32]) || (q_q[31:0] > limit);
		if (over)
			quot = neg_q ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		else
			quot = neg_q ? $signed(32'd0 - q_q[31:0]) : $signed(q_q[31:0]);
	end

endmodule

@@ src/gs_datapath.sv @@
// Datapath: matrix and vector stores, multiply-accumulate, divider and change tracking.
module gs_datapath #(
	parameter int FRAC_BITS = 16,
	parameter int IW = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  gs_pkg::gs_cmd_t      cmd,
	output gs_pkg::gs_sts_t      sts,
	input  logic                 wr_a,
	input  logic                 wr_b,
	input  logic [IW-1:0]        wr_row,
	input  logic [IW-1:0]        wr_col,
	input  logic signed [31:0]   wr_val,
	input  logic [IW-1:0]        row_i,
	input  logic [IW-1:0]        col_j,
	input  logic [30:0]          tolerance,
	output logic signed [31:0]   x_out,
	output logic [30:0]          change_out
);
	import gs_pkg::*;

	logic signed [31:0] a_mem [MAX_N*MAX_N];
	logic signed [31:0] b_mem [MAX_N];
	logic signed [31:0] x_mem [MAX_N];
	logic signed [31:0] a_rd_s1;
	logic signed [31:0] x_rd_s1;
	logic signed [31:0] diag_q;
	logic signed [31:0] b_rd_q;
	logic signed [31:0] x_old_q;
	logic               skip_s1;
	logic               valid_s1;
	logic signed [63:0] prod_s2;
	logic               valid_s2;
	logic signed [63:0] acc_q;
	logic [31:0]        worst_q;
	logic signed [31:0] quot;
	logic               div_done;
	logic [63:0]        prod_mag;
	logic signed [63:0] prod_trunc;
	logic signed [32:0] dx;
	logic [31:0]        dmag;

	always_ff @(posedge clk) begin
		if (wr_a)
			a_mem[{wr_row, wr_col}] <= wr_val;
		if (wr_b)
			b_mem[wr_row] <= wr_val;
		a_rd_s1 <= a_mem[{row_i, col_j}];
		x_rd_s1 <= x_mem[col_j];
		skip_s1 <= (row_i == col_j);
		// The row operands are captured while the row accumulates, ahead of the divider start.
		if (cmd.rd_diag || cmd.mac_step) begin
			diag_q <= a_mem[{row_i, row_i}];
			b_rd_q <= b_mem[row_i];
			x_old_q <= x_mem[row_i];
		end
		if (cmd.clear_x)
			x_mem[col_j] <= '0;
		else if (cmd.update)
			x_mem[row_i] <= quot;
		if (cmd.rd_emit)
			x_out <= x_mem[row_i];
	end

	always_comb begin
		prod_mag = prod_s2[63] ? (64'd0 - prod_s2) : prod_s2;
		prod_trunc = prod_s2[63] ? -$signed(prod_mag >> FRAC_BITS)
		                         : $signed(prod_mag >> FRAC_BITS);
		dx = {quot[31], quot} - {x_old_q[31], x_old_q};
		dmag = dx[32] ? 32'(33'd0 - dx) : dx[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= cmd.mac_step;
			valid_s2 <= valid_s1 && !skip_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= 64'(a_rd_s1) * 64'(x_rd_s1);
		if (cmd.mac_start)
			acc_q <= '0;
		else if (valid_s2)
			acc_q <= acc_q + prod_trunc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			worst_q <= '0;
			change_out <= '0;
		end else begin
			if (cmd.clear_x && col_j == '0) begin
				worst_q <= '0;
				change_out <= '0;
			end else if (cmd.update) begin
				if (dmag > worst_q)
					worst_q <= dmag;
			end else if (cmd.sweep_end) begin
				change_out <= worst_q[31] ? 31'h7FFF_FFFF : worst_q[30:0];
				worst_q <= '0;
			end
		end
	end

	gs_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (64'(b_rd_q) - acc_q),
		.den    (diag_q),
		.done   (div_done),
		.quot   (quot)
	);

	always_comb begin
		sts.diag_zero = (diag_q == '0);
		sts.div_done = div_done;
		sts.converged = (worst_q < {1'b0, tolerance});
	end

endmodule

@@ src/gs_ctrl.sv @@
// Controller: sequences loads, sweeps, convergence checks and result emission.
module gs_ctrl #(
	parameter int IW = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  gs_pkg::in_item_t  in_item,
	input  logic [4:0]        system_size,
	input  logic [15:0]       max_sweeps,
	output gs_pkg::gs_cmd_t   cmd,
	input  gs_pkg::gs_sts_t   sts,
	output logic              wr_a,
	output logic              wr_b,
	output logic [IW-1:0]     row_i,
	output logic [IW-1:0]     col_j,
	output logic              out_load,
	input  logic              out_free,
	output logic              out_last,
	output logic [1:0]        out_status,
	output logic [15:0]       out_sweeps
);
	import gs_pkg::*;

	localparam int NW = $clog2(MAX_N + 1);

	state_t        state_q, state_d;
	logic [IW-1:0] i_q, i_d, j_q, j_d;
	logic [NW-1:0] n_q, n_d;
	logic [15:0]   sw_q, sw_d;
	status_t       st_q, st_d;
	logic [1:0]    drain_q, drain_d;
	logic          accept;
	logic          i_last, j_last;
	logic [NW-1:0] n_eff;
	logic          in_rng_r, in_rng_c;

	always_comb begin
		if (system_size == 5'd0)
			n_eff = NW'(1);
		else if (32'(system_size) > MAX_N)
			n_eff = NW'(MAX_N);
		else
			n_eff = NW'(system_size);
		i_last = (NW'(i_q) == n_q - 1'b1);
		j_last = (NW'(j_q) == n_q - 1'b1);
		in_rng_r = (32'(in_item.row) < MAX_N);
		in_rng_c = (32'(in_item.column) < MAX_N);
	end

	assign in_stall = (state_q != S_IDLE);
	assign accept = in_valid && !in_stall;
	assign wr_a = accept && in_item.mode == MODE_MATRIX && in_rng_r && in_rng_c;
	assign wr_b = accept && in_item.mode == MODE_RHS && in_rng_r;
	assign row_i = i_q;
	assign col_j = j_q;
	assign out_last = i_last;
	assign out_status = st_q;
	assign out_sweeps = sw_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			i_q <= '0;
			j_q <= '0;
			n_q <= NW'(4);
			sw_q <= '0;
			st_q <= ST_CONVERGED;
			drain_q <= '0;
		end else begin
			state_q <= state_d;
			i_q <= i_d;
			j_q <= j_d;
			n_q <= n_d;
			sw_q <= sw_d;
			st_q <= st_d;
			drain_q <= drain_d;
		end
	end

	always_comb begin
		state_d = state_q;
		i_d = i_q;
		j_d = j_q;
		n_d = n_q;
		sw_d = sw_q;
		st_d = st_q;
		drain_d = drain_q;
		cmd = '0;
		out_load = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept && in_item.mode == MODE_SOLVE) begin
					n_d = n_eff;
					sw_d = '0;
					i_d = '0;
					j_d = '0;
					state_d = S_CLEAR;
				end
			end
			S_CLEAR: begin
				cmd.clear_x = 1'b1;
				if (32'(j_q) == MAX_N - 1) begin
					j_d = '0;
					state_d = S_DIAG;
				end else
					j_d = j_q + 1'b1;
			end
			S_DIAG: begin
				cmd.rd_diag = 1'b1;
				state_d = S_DIAG_CHK;
			end
			S_DIAG_CHK: begin
				if (sts.diag_zero) begin
					st_d = ST_ZERO_DIAG;
					i_d = '0;
					state_d = S_EMIT_RD;
				end else if (i_last) begin
					i_d = '0;
					if (max_sweeps == '0) begin
						st_d = ST_LIMIT;
						state_d = S_EMIT_RD;
					end else begin
						cmd.mac_start = 1'b1;
						state_d = S_MAC;
					end
				end else begin
					i_d = i_q + 1'b1;
					state_d = S_DIAG;
				end
			end
			S_MAC: begin
				cmd.mac_step = 1'b1;
				if (j_last) begin
					j_d = '0;
					drain_d = 2'd3;
					state_d = S_MAC_WAIT;
				end else
					j_d = j_q + 1'b1;
			end
			S_MAC_WAIT: begin
				// Let the read and product stages empty into the accumulator.
				drain_d = drain_q - 1'b1;
				if (drain_q == 2'd1)
					state_d = S_DIV;
			end
			S_DIV: begin
				cmd.div_start = 1'b1;
				state_d = S_DIV_WAIT;
			end
			S_DIV_WAIT: begin
				if (sts.div_done)
					state_d = S_UPDATE;
			end
			S_UPDATE: begin
				cmd.update = 1'b1;
				if (i_last) begin
					i_d = '0;
					sw_d = sw_q + 1'b1;
					state_d = S_SWEEP_END;
				end else begin
					i_d = i_q + 1'b1;
					cmd.mac_start = 1'b1;
					state_d = S_MAC;
				end
			end
			S_SWEEP_END: begin
				cmd.sweep_end = 1'b1;
				if (sts.converged) begin
					st_d = ST_CONVERGED;
					state_d = S_EMIT_RD;
				end else if (sw_q >= max_sweeps) begin
					st_d = ST_LIMIT;
					state_d = S_EMIT_RD;
				end else begin
					cmd.mac_start = 1'b1;
					state_d = S_MAC;
				end
			end
			S_EMIT_RD: begin
				cmd.rd_emit = 1'b1;
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (out_free) begin
					out_load = 1'b1;
					if (i_last) begin
						i_d = '0;
						state_d = S_IDLE;
					end else begin
						i_d = i_q + 1'b1;
						state_d = S_EMIT_RD;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	a_update_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update |-> (state_q == S_UPDATE && $past(state_q) == S_DIV_WAIT))
		else $error("unknown updated outside a division result");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !accept)
		else $error("item accepted while solving");
	a_sweep_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MAC) |-> (sw_q < max_sweeps))
		else $error("sweep started past the limit");
	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT) |-> (NW'(i_q) < n_q))
		else $error("emit index beyond system size");

endmodule
